/* design/interval_overlap_counter_macros.svh */
// Assertion macros used by the interval overlap counter top level.
`ifndef INTERVAL_OVERLAP_COUNTER_MACROS_SVH
`define INTERVAL_OVERLAP_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on i_clk and held off during reset.
`define IOC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and held off during reset.
`define IOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ioc_pkg.sv */
// Types and constants shared by the interval overlap counter modules.
package ioc_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] interval_start;
        logic [31:0] interval_length;
        logic        final_query;
    } t_in_item;

    typedef struct packed {
        logic [10:0] overlap_count;
        logic [31:0] running_total;
    } t_out_item;

    // One stored reference interval.
    typedef struct packed {
        logic [31:0] len;
        logic [31:0] start;
    } t_entry;

    // Table write request from the control side.
    typedef struct packed {
        logic   en;
        t_entry entry;
    } t_wr_req;

    // Query launch: start pulse, query start and 33-bit query end.
    typedef struct packed {
        logic        start;
        logic [31:0] qs;
        logic [32:0] qe;
    } t_query_cmd;

endpackage

/* design/interval_overlap_counter.sv */
// Top level of the interval overlap counter: handshakes, table fill, running total.
//
// Usage: items arrive on the input channel (i_in_valid, o_in_ready, i_in_data).
// A clear empties the table and zeroes the running total; an append
// writes the next table entry and is dropped when the table is full.
// Neither produces a transfer on the output channel. A query is answered by one
// transfer on the output channel (o_out_valid, i_out_ready, o_out_data) that
// carries the overlap count and the saturating running total.
// The block works on one query at a time. A query takes two binary searches
// over the stored starts at one memory read per cycle, then three boundary reads,
// all through the single read port of the reference memory.
// Stalls: the result sits in an output register; the next item is taken while it
// waits, and a further query holds its result until that register is free.
// Reset: synchronous, active low; clears the entry count, the running total and
// the output valid. Table contents are left as they are; a stale entry may be
// read during a query, but its value is never used.
`include "interval_overlap_counter_macros.svh"

module interval_overlap_counter import ioc_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {T_IDLE, T_BUSY, T_EMIT} t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_stored;
    logic [31:0]      r_sum;
    logic             r_final;
    t_query_cmd       r_cmd;
    logic [CNT_W-1:0] r_pend;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic              in_fire;
    logic              emit;
    t_wr_req           wr;
    logic              eng_done;
    logic [CNT_W-1:0]  eng_count;
    logic [32:0]       sum33;
    logic [31:0]       new_total;
    logic [CNT_W+10:0] ovl_ext;

    // New items are taken only while no query is in flight.
    assign o_in_ready = (r_state == T_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    // A finished count moves to the output register once that register is free.
    assign emit = (r_state == T_EMIT) && (!r_out_valid || i_out_ready);

    // Appends go straight into the table at the current fill position.
    always_comb begin
        wr.en          = in_fire && (i_in_data.opcode == OP_APPEND) && (r_stored < DEPTH_C);
        wr.entry.start = i_in_data.interval_start;
        wr.entry.len   = i_in_data.interval_length;
    end

    // The running total saturates rather than wrapping.
    always_comb begin
        sum33     = {1'b0, r_sum} + 33'(r_pend);
        new_total = sum33[32] ? TOTAL_MAX : sum33[31:0];
        ovl_ext   = {11'b0, r_pend};
    end

    ioc_engine #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_wr_addr (r_stored[IDX_W-1:0]),
        .i_cmd     (r_cmd),
        .i_count_n (r_stored),
        .o_done    (eng_done),
        .o_count   (eng_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_stored    <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_cmd.start <= 1'b0;
        end else begin
            r_cmd.start <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (in_fire) begin
                        unique case (i_in_data.opcode)
                            OP_CLEAR: begin
                                r_stored <= '0;
                                r_sum    <= '0;
                            end
                            OP_APPEND: begin
                                if (r_stored < DEPTH_C) begin
                                    r_stored <= r_stored + CNT_W'(1);
                                end
                            end
                            OP_QUERY: begin
                                // The query end is formed one bit wider so it cannot wrap.
                                r_cmd.start <= 1'b1;
                                r_cmd.qs    <= i_in_data.interval_start;
                                r_cmd.qe    <= {1'b0, i_in_data.interval_start} +
                                               {1'b0, i_in_data.interval_length};
                                r_final     <= i_in_data.final_query;
                                r_state     <= T_BUSY;
                            end
                            default: begin
                                // The unused opcode is consumed without effect.
                                r_state <= T_IDLE;
                            end
                        endcase
                    end
                end
                T_BUSY: begin
                    if (eng_done) begin
                        r_pend  <= eng_count;
                        r_state <= T_EMIT;
                    end
                end
                T_EMIT: begin
                    if (emit) begin
                        r_out_valid                <= 1'b1;
                        r_out_data.overlap_count   <= ovl_ext[10:0];
                        r_out_data.running_total   <= new_total;
                        // A final query reports its total, then starts a fresh sum.
                        r_sum   <= r_final ? '0 : new_total;
                        r_state <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `IOC_ASSERT_IMPL(a_done_in_busy, eng_done, r_state == T_BUSY, "engine finished with no query in flight")
    `IOC_ASSERT_IMPL(a_count_bound, eng_done, eng_count <= r_stored, "overlap count above entry count")
    `IOC_ASSERT_IMPL(a_stored_bound, 1'b1, r_stored <= DEPTH_C, "entry count above table depth")
    `IOC_ASSERT_NEXT(a_total_covers, emit, r_out_valid && (r_out_data.running_total >= 32'(r_pend)), "running total below its own count")

endmodule

/* design/ioc_engine.sv */
// Reference table memory and the binary-search query sequencer.
module ioc_engine import ioc_pkg::*; #(
    parameter  int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int IDX_W       = $clog2(TABLE_DEPTH),
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_wr_req          i_wr,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_query_cmd       i_cmd,
    input  logic [CNT_W-1:0] i_count_n,
    output logic             o_done,
    output logic [CNT_W-1:0] o_count
);

    typedef enum logic [2:0] {E_IDLE, E_SRCH, E_B1, E_B2, E_B3} t_estate;

    t_entry           r_mem [TABLE_DEPTH];
    t_entry           r_rdata;
    t_estate          r_state;
    logic             r_phase;
    logic [31:0]      r_qs;
    logic [32:0]      r_qe;
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_lo1;
    logic [CNT_W-1:0] r_hi;
    logic [IDX_W-1:0] r_mid;
    logic [CNT_W-1:0] r_left;
    logic [CNT_W-1:0] r_right;
    logic             r_hit_l;
    logic             r_reach;
    logic             r_done;
    logic [CNT_W-1:0] r_count;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [32:0]      key;
    logic             less;
    logic [CNT_W-1:0] lo1_nx;
    logic [CNT_W-1:0] hi_nx;
    logic             more;
    logic [CNT_W-1:0] left_m1;
    logic             hit_r;
    logic [CNT_W+1:0] rs;
    logic [CNT_W+1:0] re;
    logic [CNT_W+1:0] diff;
    logic [CNT_W-1:0] cnt;

    // Midpoint of the open window (lo1 - 1, hi); valid only while hi > lo1.
    function automatic logic [IDX_W-1:0] mid_of(input logic [CNT_W-1:0] lo1,
                                                 input logic [CNT_W-1:0] hi);
        logic [CNT_W-1:0] m;
        m = lo1 + ((hi - lo1 - CNT_W'(1)) >> 1);
        return m[IDX_W-1:0];
    endfunction

    // One search step per cycle: the stored start at r_mid is in r_rdata.
    always_comb begin
        key    = r_phase ? r_qe : {1'b0, r_qs};
        less   = {1'b0, r_rdata.start} < key;
        lo1_nx = less ? CNT_W'(r_mid) + CNT_W'(1) : r_lo1;
        hi_nx  = less ? r_hi : CNT_W'(r_mid);
        more   = hi_nx > lo1_nx;
    end

    always_comb begin
        left_m1 = r_left - CNT_W'(1);
        hit_r   = (r_right < r_n) && ({1'b0, r_rdata.start} == r_qe);
        rs      = {2'b00, r_left} - ((!r_hit_l && r_reach) ? (CNT_W+2)'(1) : '0);
        re      = {2'b00, r_right} - (hit_r ? '0 : (CNT_W+2)'(1));
        diff    = re - rs + (CNT_W+2)'(1);
        cnt     = (!diff[CNT_W+1] && (diff != '0)) ? diff[CNT_W-1:0] : '0;
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_mid;
        case (r_state)
            E_IDLE: begin
                if (i_cmd.start && (i_count_n != '0)) begin
                    rd_en   = 1'b1;
                    rd_addr = mid_of('0, i_count_n);
                end
            end
            E_SRCH: begin
                rd_en = 1'b1;
                if (more) begin
                    rd_addr = mid_of(lo1_nx, hi_nx);
                end else if (!r_phase) begin
                    rd_addr = mid_of('0, r_n);
                end else begin
                    rd_addr = r_left[IDX_W-1:0];
                end
            end
            E_B1: begin
                rd_en   = 1'b1;
                rd_addr = left_m1[IDX_W-1:0];
            end
            E_B2: begin
                rd_en   = 1'b1;
                rd_addr = r_right[IDX_W-1:0];
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                E_IDLE: begin
                    if (i_cmd.start) begin
                        r_qs    <= i_cmd.qs;
                        r_qe    <= i_cmd.qe;
                        r_n     <= i_count_n;
                        r_phase <= 1'b0;
                        r_lo1   <= '0;
                        r_hi    <= i_count_n;
                        r_mid   <= rd_addr;
                        if (i_count_n != '0) begin
                            r_state <= E_SRCH;
                        end else begin
                            // Empty table: both searches land on index zero.
                            r_left  <= '0;
                            r_right <= '0;
                            r_state <= E_B1;
                        end
                    end
                end
                E_SRCH: begin
                    r_mid <= rd_addr;
                    if (more) begin
                        r_lo1 <= lo1_nx;
                        r_hi  <= hi_nx;
                    end else if (!r_phase) begin
                        r_left  <= hi_nx;
                        r_phase <= 1'b1;
                        r_lo1   <= '0;
                        r_hi    <= r_n;
                    end else begin
                        r_right <= hi_nx;
                        r_state <= E_B1;
                    end
                end
                E_B1: begin
                    r_hit_l <= (r_left < r_n) && (r_rdata.start == r_qs);
                    r_state <= E_B2;
                end
                E_B2: begin
                    r_reach <= (r_left != '0) &&
                               ({1'b0, r_qs} <= ({1'b0, r_rdata.start} + {1'b0, r_rdata.len}));
                    r_state <= E_B3;
                end
                E_B3: begin
                    r_count <= cnt;
                    r_done  <= 1'b1;
                    r_state <= E_IDLE;
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_count = r_count;

endmodule
